/* rtl/pbso_pkg.sv */
package pbso_pkg;

    localparam int MAX_BANDS = 16;
    localparam int BAND_AW   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;

    localparam int IDX_W     = 4;
    localparam int DIV_W     = 8;
    localparam int SPEED_W   = 8;
    localparam int MOTION_W  = 3;
    localparam int CAM_W     = 15;
    localparam int OFFSET_W  = 12;
    localparam int ACC_W     = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // shared divider width
    localparam int QW     = 16;
    localparam int QCNT_W = $clog2(QW + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 2'd2;

    localparam logic [1:0] SCROLL_HORIZ = 2'd0;
    localparam logic [1:0] SCROLL_VERT  = 2'd1;

    localparam logic [OFFSET_W-1:0] PLANE_WIDTH_RST  = 12'd640;
    localparam logic [OFFSET_W-1:0] PLANE_HEIGHT_RST = 12'd256;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [MOTION_W-1:0] MOTION_CAMERA    = 3'd0;
    localparam logic [MOTION_W-1:0] MOTION_AUTO_FWD  = 3'd1;
    localparam logic [MOTION_W-1:0] MOTION_AUTO_BACK = 3'd2;
    localparam logic [MOTION_W-1:0] MOTION_COMB_FWD  = 3'd4;
    localparam logic [MOTION_W-1:0] MOTION_COMB_BACK = 3'd5;

    typedef enum logic [2:0] {
        SRC_CAM,
        SRC_QUO,
        SRC_CAM2,
        SRC_ACC,
        SRC_SPD
    } div_src_t;

    typedef struct packed {
        logic     load;
        logic     div_go;
        logic     div_wait;
        div_src_t div_src;
        logic     step;
        logic     finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic skip;
        logic empty;
        logic cam_only;
        logic combined;
        logic acc_big;
        logic spd_big;
        logic div_done;
        logic out_free;
    } ctl_stat_t;

endpackage

/* rtl/pbso_in_if.sv */
interface pbso_in_if import pbso_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [IDX_W-1:0]    band_index;
    logic                band_empty;
    logic [DIV_W-1:0]    divisor;
    logic [SPEED_W-1:0]  speed;
    logic [MOTION_W-1:0] motion_mode;
    logic [CAM_W-1:0]    camera_x;
    logic [CAM_W-1:0]    camera_y;

    modport source (
        output valid, cmd, band_index, band_empty, divisor, speed, motion_mode,
               camera_x, camera_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, band_index, band_empty, divisor, speed, motion_mode,
               camera_x, camera_y,
        output ready
    );
endinterface

/* rtl/pbso_out_if.sv */
interface pbso_out_if import pbso_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OFFSET_W-1:0] band_offset;

    modport source (
        output valid, band_offset,
        input  ready
    );
    modport sink (
        input  valid, band_offset,
        output ready
    );
endinterface

/* rtl/pbso_div.sv */
module pbso_div import pbso_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [QW-1:0] dividend,
    input  logic [QW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient,
    output logic [QW-1:0] remainder
);

    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [QW-1:0]     rem_reg, rem_next;
    logic [QW-1:0]     dvs_reg, dvs_next;
    logic [QW:0]       shifted;
    logic [QW:0]       trial;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[QW-1]};
        trial     = shifted - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = QCNT_W'(QW);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == QCNT_W'(1));
            if (!trial[QW])
            begin
                rem_next = trial[QW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[QW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/pbso_dp.sv */
module pbso_dp import pbso_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_cmd,
    input  logic [IDX_W-1:0]      in_band_index,
    input  logic                  in_band_empty,
    input  logic [DIV_W-1:0]      in_divisor,
    input  logic [SPEED_W-1:0]    in_speed,
    input  logic [MOTION_W-1:0]   in_motion_mode,
    input  logic [CAM_W-1:0]      in_camera_x,
    input  logic [CAM_W-1:0]      in_camera_y,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OFFSET_W-1:0]   out_band_offset,
    input  ctl_cmd_t              cmd,
    output ctl_stat_t             stat
);

    logic [1:0]          scroll_mode_reg;
    logic [OFFSET_W-1:0] plane_width_reg;
    logic [OFFSET_W-1:0] plane_height_reg;

    logic [ACC_W-1:0]    acc_mem [MAX_BANDS];
    logic [OFFSET_W-1:0] off_mem [MAX_BANDS];

    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_offset_reg;

    // item registers
    logic                cmd_reg;
    logic [BAND_AW-1:0]  idx_reg;
    logic                in_range_reg;
    logic                empty_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [MOTION_W-1:0] mode_reg;
    logic [CAM_W-1:0]    cam_reg;
    logic [OFFSET_W-1:0] m_reg;
    logic [OFFSET_W-1:0] o_reg;
    logic [ACC_W-1:0]    a_reg, a_next;
    logic [SPEED_W-1:0]  s_reg, s_next;
    logic [CAM_W-1:0]    q_reg, q_next;
    logic [OFFSET_W-1:0] t_reg, t_next;

    logic [BAND_AW-1:0]  in_idx;
    logic                in_range;
    logic [OFFSET_W-1:0] m_raw;
    logic [ACC_W-1:0]    m16;
    logic                hold_mode;
    logic                auto_mode;
    logic                combined;
    logic                fwd;
    logic                is_static;
    logic [ACC_W:0]      step_sum;
    logic [ACC_W:0]      step_red;
    logic [OFFSET_W:0]   comb_sum;
    logic [OFFSET_W-1:0] comb_red;
    logic [OFFSET_W-1:0] result;
    logic                fin_fire;

    logic                dv_done;
    logic [QW-1:0]       dv_dividend;
    logic [QW-1:0]       dv_divisor;
    logic [QW-1:0]       dv_quo;
    logic [QW-1:0]       dv_rem;

    assign in_idx   = BAND_AW'(in_band_index);
    assign in_range = (32'(in_band_index) < MAX_BANDS);
    assign m_raw    = (scroll_mode_reg == SCROLL_HORIZ) ? {1'b0, plane_width_reg[OFFSET_W-1:1]}
                                                        : plane_height_reg;
    assign m16      = {m_reg, 4'b0000};

    assign hold_mode = !((mode_reg == MOTION_CAMERA) || (mode_reg == MOTION_AUTO_FWD) ||
                         (mode_reg == MOTION_AUTO_BACK) || (mode_reg == MOTION_COMB_FWD) ||
                         (mode_reg == MOTION_COMB_BACK));
    assign combined  = (mode_reg == MOTION_COMB_FWD) || (mode_reg == MOTION_COMB_BACK);
    assign auto_mode = combined || (mode_reg == MOTION_AUTO_FWD) ||
                       (mode_reg == MOTION_AUTO_BACK);
    assign fwd       = (mode_reg == MOTION_AUTO_FWD) || (mode_reg == MOTION_COMB_FWD);
    assign is_static = scroll_mode_reg[1];

    always_comb
    begin
        dv_dividend = '0;
        dv_divisor  = m16;
        case (cmd.div_src)
            SRC_CAM:
            begin
                dv_dividend = QW'(cam_reg);
                dv_divisor  = QW'(div_reg);
            end
            SRC_QUO:
            begin
                dv_dividend = QW'(q_reg);
                dv_divisor  = QW'(m_reg);
            end
            SRC_CAM2:
            begin
                dv_dividend = {cam_reg, 1'b0};
                dv_divisor  = QW'(m_reg);
            end
            SRC_ACC:
            begin
                dv_dividend = a_reg;
                dv_divisor  = m16;
            end
            SRC_SPD:
            begin
                dv_dividend = QW'(s_reg);
                dv_divisor  = m16;
            end
            default:
            begin
                dv_dividend = '0;
                dv_divisor  = m16;
            end
        endcase
    end

    pbso_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_go),
        .dividend  (dv_dividend),
        .divisor   (dv_divisor),
        .done      (dv_done),
        .quotient  (dv_quo),
        .remainder (dv_rem)
    );

    // accumulator step, both operands already below 16*M
    always_comb
    begin
        if (fwd)
        begin
            step_sum = {1'b0, a_reg} + (ACC_W+1)'(s_reg);
        end
        else
        begin
            step_sum = {1'b0, a_reg} + {1'b0, m16} - (ACC_W+1)'(s_reg);
        end
        step_red = (step_sum >= {1'b0, m16}) ? step_sum - {1'b0, m16} : step_sum;
        comb_sum = {1'b0, t_reg} + {1'b0, a_reg[ACC_W-1:4]};
        comb_red = (comb_sum >= {1'b0, m_reg}) ? OFFSET_W'(comb_sum - {1'b0, m_reg})
                                               : comb_sum[OFFSET_W-1:0];
    end

    always_comb
    begin
        if (!in_range_reg || (cmd_reg == CMD_CLEAR))
        begin
            result = '0;
        end
        else if (is_static)
        begin
            result = o_reg;
        end
        else if (empty_reg || (mode_reg == MOTION_CAMERA))
        begin
            result = t_reg;
        end
        else if (combined)
        begin
            result = comb_red;
        end
        else if (auto_mode)
        begin
            result = a_reg[ACC_W-1:4];
        end
        else
        begin
            result = o_reg;
        end
    end

    always_comb
    begin
        a_next = a_reg;
        s_next = s_reg;
        q_next = q_reg;
        t_next = t_reg;
        if (cmd.load)
        begin
            a_next = in_range ? acc_mem[in_idx] : '0;
            s_next = in_speed;
        end
        else if (cmd.div_wait && dv_done)
        begin
            case (cmd.div_src)
                SRC_CAM:  q_next = dv_quo[CAM_W-1:0];
                SRC_QUO:  t_next = dv_rem[OFFSET_W-1:0];
                SRC_CAM2: t_next = dv_rem[OFFSET_W-1:0];
                SRC_ACC:  a_next = dv_rem;
                SRC_SPD:  s_next = dv_rem[SPEED_W-1:0];
                default:  t_next = t_reg;
            endcase
        end
        else if (cmd.step)
        begin
            a_next = step_red[ACC_W-1:0];
        end
    end

    assign fin_fire = cmd.finish && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        s_reg <= s_next;
        q_reg <= q_next;
        t_reg <= t_next;
        if (cmd.load)
        begin
            cmd_reg      <= in_cmd;
            idx_reg      <= in_idx;
            in_range_reg <= in_range;
            empty_reg    <= in_band_empty;
            div_reg      <= (in_divisor == '0) ? DIV_W'(1) : in_divisor;
            mode_reg     <= in_motion_mode;
            cam_reg      <= (scroll_mode_reg == SCROLL_HORIZ) ? in_camera_x : in_camera_y;
            m_reg        <= (m_raw == '0) ? OFFSET_W'(1) : m_raw;
            o_reg        <= in_range ? off_mem[in_idx] : '0;
        end
        if (fin_fire)
        begin
            out_offset_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_mode_reg  <= SCROLL_HORIZ;
            plane_width_reg  <= PLANE_WIDTH_RST;
            plane_height_reg <= PLANE_HEIGHT_RST;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_BANDS; i++)
            begin
                acc_mem[i] <= '0;
                off_mem[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCROLL_MODE:  scroll_mode_reg  <= cfg_data[1:0];
                    CFG_PLANE_WIDTH:  plane_width_reg  <= cfg_data;
                    CFG_PLANE_HEIGHT: plane_height_reg <= cfg_data;
                    default:          scroll_mode_reg  <= scroll_mode_reg;
                endcase
            end
            if (fin_fire)
            begin
                out_valid_reg <= 1'b1;
                if (in_range_reg)
                begin
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        acc_mem[idx_reg] <= '0;
                        off_mem[idx_reg] <= '0;
                    end
                    else if (!is_static)
                    begin
                        off_mem[idx_reg] <= result;
                        if (!empty_reg && auto_mode)
                        begin
                            acc_mem[idx_reg] <= a_reg;
                        end
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_band_offset = out_offset_reg;

    always_comb
    begin
        stat.skip     = !in_range_reg || (cmd_reg == CMD_CLEAR) || is_static ||
                        (!empty_reg && hold_mode);
        stat.empty    = empty_reg;
        stat.cam_only = (mode_reg == MOTION_CAMERA);
        stat.combined = combined;
        stat.acc_big  = (a_reg >= m16);
        stat.spd_big  = (QW'(s_reg) >= m16);
        stat.div_done = dv_done;
        stat.out_free = !out_valid_reg || out_ready;
    end

endmodule

/* rtl/pbso_ctrl.sv */
module pbso_ctrl import pbso_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_CAM_GO,
        S_CAM_WAIT,
        S_QM_GO,
        S_QM_WAIT,
        S_E2_GO,
        S_E2_WAIT,
        S_ACC_GO,
        S_ACC_WAIT,
        S_SPD_GO,
        S_SPD_WAIT,
        S_STEP,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.div_src  = SRC_CAM;
        in_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.skip)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.empty)
                begin
                    state_next = S_E2_GO;
                end
                else if (stat.cam_only)
                begin
                    state_next = S_CAM_GO;
                end
                else if (stat.acc_big)
                begin
                    state_next = S_ACC_GO;
                end
                else if (stat.spd_big)
                begin
                    state_next = S_SPD_GO;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_CAM_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_src = SRC_CAM;
                state_next  = S_CAM_WAIT;
            end
            S_CAM_WAIT:
            begin
                cmd.div_wait = 1'b1;
                cmd.div_src  = SRC_CAM;
                if (stat.div_done)
                begin
                    state_next = S_QM_GO;
                end
            end
            S_QM_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_src = SRC_QUO;
                state_next  = S_QM_WAIT;
            end
            S_QM_WAIT:
            begin
                cmd.div_wait = 1'b1;
                cmd.div_src  = SRC_QUO;
                if (stat.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_E2_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_src = SRC_CAM2;
                state_next  = S_E2_WAIT;
            end
            S_E2_WAIT:
            begin
                cmd.div_wait = 1'b1;
                cmd.div_src  = SRC_CAM2;
                if (stat.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_ACC_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_src = SRC_ACC;
                state_next  = S_ACC_WAIT;
            end
            S_ACC_WAIT:
            begin
                cmd.div_wait = 1'b1;
                cmd.div_src  = SRC_ACC;
                if (stat.div_done)
                begin
                    state_next = stat.spd_big ? S_SPD_GO : S_STEP;
                end
            end
            S_SPD_GO:
            begin
                cmd.div_go  = 1'b1;
                cmd.div_src = SRC_SPD;
                state_next  = S_SPD_WAIT;
            end
            S_SPD_WAIT:
            begin
                cmd.div_wait = 1'b1;
                cmd.div_src  = SRC_SPD;
                if (stat.div_done)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = stat.combined ? S_CAM_GO : S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/parallax_band_scroll_offset.sv */
// channel  dir  payload                                               transaction
// in_ch    in   cmd band_index band_empty divisor speed motion_mode   valid & ready
//               camera_x camera_y
// out_ch   out  band_offset                                           valid & ready
// cfg      in   cfg_index cfg_data                                    cfg_we
//
// One item at a time through a shared 16-bit restoring divider (one bit per cycle).
// Each item runs D divisions, plus a step state in auto and combined modes; D divisions:
// 0 clear/static/hold, 1 empty band, 2 camera, 0-2 auto, 2-4 combined.
// Reset loads the register defaults and clears all band stores at once.
// A new item is taken while a result waits in the output register; the block
// stalls in its finish state only if that register is still full.
module parallax_band_scroll_offset import pbso_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    pbso_in_if.sink               in_ch,
    pbso_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    pbso_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pbso_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_cmd          (in_ch.cmd),
        .in_band_index   (in_ch.band_index),
        .in_band_empty   (in_ch.band_empty),
        .in_divisor      (in_ch.divisor),
        .in_speed        (in_ch.speed),
        .in_motion_mode  (in_ch.motion_mode),
        .in_camera_x     (in_ch.camera_x),
        .in_camera_y     (in_ch.camera_y),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_band_offset (out_ch.band_offset),
        .cmd             (cmd),
        .stat            (stat)
    );

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input taken while an item is in flight");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.band_offset <= 12'd4094))
        else $error("band offset out of range");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> cmd.div_wait)
        else $error("divider finished with no one waiting");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && !stat.out_free |=> cmd.finish)
        else $error("result dropped while output register full");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
    import pbso_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int CHUNK       = 40;
    localparam int CHUNKS      = 5;

    localparam logic [1:0]          SCROLL_STATIC     = 2'd2;
    localparam logic [1:0]          SCROLL_STATIC_ALT = 2'd3;
    localparam logic [MOTION_W-1:0] MOTION_HOLD_LO    = 3'd3;
    localparam logic [MOTION_W-1:0] MOTION_HOLD_MID   = 3'd6;
    localparam logic [MOTION_W-1:0] MOTION_HOLD_HI    = 3'd7;

    typedef struct packed {
        logic                cmd;
        logic [IDX_W-1:0]    band;
        logic                empty;
        logic [DIV_W-1:0]    divisor;
        logic [SPEED_W-1:0]  speed;
        logic [MOTION_W-1:0] motion;
        logic [CAM_W-1:0]    cam_x;
        logic [CAM_W-1:0]    cam_y;
    } band_req_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pbso_in_if  in_ch ();
    pbso_out_if out_ch ();

    parallax_band_scroll_offset dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the block's registers and band stores
    logic [1:0]          scroll_sel;
    logic [OFFSET_W-1:0] plane_w;
    logic [OFFSET_W-1:0] plane_h;
    logic [ACC_W-1:0]    acc_mirror    [MAX_BANDS];
    logic [OFFSET_W-1:0] offset_mirror [MAX_BANDS];

    band_req_t           pending [$];
    logic [OFFSET_W-1:0] offset_due [$];

    band_req_t drv_req;
    band_req_t taken;
    int        send_gap_pct;
    int        recv_stall_pct;
    int        fail_count;
    int        cycle_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int unsigned parallax_term(int unsigned cam, int unsigned dv,
                                                  int unsigned m);
        return ((cam + m * dv) / dv) % m;
    endfunction

    function automatic logic [OFFSET_W-1:0] next_band_offset(band_req_t r);
        int unsigned m;
        int unsigned m16;
        int unsigned cam;
        int unsigned dv;
        int unsigned acc;
        int unsigned off;
        if (r.band >= MAX_BANDS)
            return '0;
        if (r.cmd == CMD_CLEAR)
        begin
            acc_mirror[r.band]    = '0;
            offset_mirror[r.band] = '0;
            return '0;
        end
        if (scroll_sel != SCROLL_HORIZ && scroll_sel != SCROLL_VERT)
            return offset_mirror[r.band];
        if (scroll_sel == SCROLL_HORIZ)
        begin
            m   = plane_w >> 1;
            cam = r.cam_x;
        end
        else
        begin
            m   = plane_h;
            cam = r.cam_y;
        end
        if (m == 0)
            m = 1;
        dv  = (r.divisor == 0) ? 1 : r.divisor;
        m16 = 16 * m;
        off = offset_mirror[r.band];
        if (r.empty)
            off = (2 * cam) % m;
        else
        begin
            case (r.motion)
                MOTION_CAMERA:
                    off = parallax_term(cam, dv, m);
                MOTION_AUTO_FWD, MOTION_AUTO_BACK, MOTION_COMB_FWD, MOTION_COMB_BACK:
                begin
                    acc = acc_mirror[r.band] % m16;
                    if (r.motion == MOTION_AUTO_FWD || r.motion == MOTION_COMB_FWD)
                        acc = (acc + r.speed) % m16;
                    else
                        acc = (acc + m16 - (r.speed % m16)) % m16;
                    acc_mirror[r.band] = acc[ACC_W-1:0];
                    if (r.motion == MOTION_AUTO_FWD || r.motion == MOTION_AUTO_BACK)
                        off = acc >> 4;
                    else
                        off = (parallax_term(cam, dv, m) + (acc >> 4)) % m;
                end
                default:
                    ;
            endcase
        end
        offset_mirror[r.band] = off[OFFSET_W-1:0];
        return off[OFFSET_W-1:0];
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                taken = {in_ch.cmd, in_ch.band_index, in_ch.band_empty, in_ch.divisor,
                         in_ch.speed, in_ch.motion_mode, in_ch.camera_x, in_ch.camera_y};
                offset_due.push_back(next_band_offset(taken));
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    drv_req = pending.pop_front();
                    in_ch.cmd         <= drv_req.cmd;
                    in_ch.band_index  <= drv_req.band;
                    in_ch.band_empty  <= drv_req.empty;
                    in_ch.divisor     <= drv_req.divisor;
                    in_ch.speed       <= drv_req.speed;
                    in_ch.motion_mode <= drv_req.motion;
                    in_ch.camera_x    <= drv_req.cam_x;
                    in_ch.camera_y    <= drv_req.cam_y;
                    in_ch.valid       <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (offset_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: band_offset %0d",
                                 out_ch.band_offset);
                end
                else if (offset_due[0] !== out_ch.band_offset)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("band_offset mismatch: expected %0d actual %0d",
                                 offset_due[0], out_ch.band_offset);
                    void'(offset_due.pop_front());
                end
                else
                    void'(offset_due.pop_front());
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic drain();
        do
            @(negedge clk);
        while (pending.size() != 0 || in_ch.valid || offset_due.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SCROLL_MODE:  scroll_sel = val[1:0];
            CFG_PLANE_WIDTH:  plane_w    = val;
            CFG_PLANE_HEIGHT: plane_h    = val;
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [1:0] sm, logic [CFG_DATA_W-1:0] w,
                              logic [CFG_DATA_W-1:0] h);
        drain();
        write_reg(CFG_SCROLL_MODE, {{(CFG_DATA_W-2){1'b0}}, sm});
        write_reg(CFG_PLANE_WIDTH, w);
        write_reg(CFG_PLANE_HEIGHT, h);
        @(negedge clk);
    endtask

    function automatic void push_req(logic cmd, int band, logic empty, int dv, int spd,
                                     logic [MOTION_W-1:0] mo, int cx, int cy);
        band_req_t r;
        r.cmd     = cmd;
        r.band    = band[IDX_W-1:0];
        r.empty   = empty;
        r.divisor = dv[DIV_W-1:0];
        r.speed   = spd[SPEED_W-1:0];
        r.motion  = mo;
        r.cam_x   = cx[CAM_W-1:0];
        r.cam_y   = cy[CAM_W-1:0];
        pending.push_back(r);
    endfunction

    function automatic int pick_cam();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 32767;
            default: return $urandom_range(32767);
        endcase
    endfunction

    function automatic band_req_t rand_req();
        band_req_t r;
        r.cmd   = ($urandom_range(99) < 8) ? CMD_CLEAR : CMD_UPDATE;
        r.band  = IDX_W'(($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(15));
        r.empty = ($urandom_range(99) < 10);
        case ($urandom_range(9))
            0:       r.divisor = '0;
            1:       r.divisor = DIV_W'(1);
            2:       r.divisor = DIV_W'(255);
            default: r.divisor = DIV_W'($urandom_range(255));
        endcase
        if ($urandom_range(9) == 0)
            r.speed = ($urandom_range(1) != 0) ? SPEED_W'(255) : '0;
        else
            r.speed = SPEED_W'($urandom_range(255));
        if ($urandom_range(99) < 60)
        begin
            case ($urandom_range(3))
                0:       r.motion = MOTION_AUTO_FWD;
                1:       r.motion = MOTION_AUTO_BACK;
                2:       r.motion = MOTION_COMB_FWD;
                default: r.motion = MOTION_COMB_BACK;
            endcase
        end
        else
            r.motion = MOTION_W'($urandom_range(7));
        r.cam_x = CAM_W'(pick_cam());
        r.cam_y = CAM_W'(pick_cam());
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_plane(int floor_val);
        case ($urandom_range(7))
            0:       return CFG_DATA_W'(floor_val);
            1:       return CFG_DATA_W'(1);
            2:       return CFG_DATA_W'(4095);
            3:       return CFG_DATA_W'($urandom_range(16, 2));
            default: return CFG_DATA_W'($urandom_range(4095, 2));
        endcase
    endfunction

    initial
    begin
        logic [1:0] sm;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_UPDATE;
        in_ch.band_index  = '0;
        in_ch.band_empty  = 1'b0;
        in_ch.divisor     = '0;
        in_ch.speed       = '0;
        in_ch.motion_mode = MOTION_CAMERA;
        in_ch.camera_x    = '0;
        in_ch.camera_y    = '0;
        out_ch.ready      = 1'b0;
        fail_count        = 0;
        cycle_count       = 0;
        scroll_sel        = SCROLL_HORIZ;
        plane_w           = PLANE_WIDTH_RST;
        plane_h           = PLANE_HEIGHT_RST;
        for (int b = 0; b < MAX_BANDS; b++)
        begin
            acc_mirror[b]    = '0;
            offset_mirror[b] = '0;
        end
        send_gap_pct   = 6;
        recv_stall_pct = 79;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: horizontal, wrap 320
        push_req(CMD_CLEAR, 0, 1'b1, 255, 255, MOTION_HOLD_HI, 32767, 32767);
        push_req(CMD_UPDATE, 0, 1'b0, 0, 0, MOTION_CAMERA, 32767, 0);
        push_req(CMD_UPDATE, 15, 1'b0, 255, 0, MOTION_CAMERA, 0, 32767);
        push_req(CMD_UPDATE, 1, 1'b0, 1, 255, MOTION_AUTO_FWD, 0, 0);
        push_req(CMD_UPDATE, 1, 1'b0, 1, 255, MOTION_AUTO_FWD, 0, 0);
        push_req(CMD_UPDATE, 2, 1'b0, 1, 255, MOTION_AUTO_BACK, 0, 0);
        push_req(CMD_UPDATE, 3, 1'b0, 3, 17, MOTION_COMB_FWD, 1000, 0);
        push_req(CMD_UPDATE, 3, 1'b0, 7, 255, MOTION_COMB_BACK, 32767, 0);
        push_req(CMD_UPDATE, 1, 1'b0, 2, 9, MOTION_HOLD_LO, 500, 0);
        push_req(CMD_UPDATE, 1, 1'b0, 2, 9, MOTION_HOLD_MID, 500, 0);
        push_req(CMD_UPDATE, 1, 1'b0, 2, 9, MOTION_HOLD_HI, 500, 0);
        push_req(CMD_UPDATE, 4, 1'b1, 5, 40, MOTION_AUTO_FWD, 32767, 0);
        push_req(CMD_CLEAR, 1, 1'b0, 0, 0, MOTION_AUTO_FWD, 0, 0);

        set_config(SCROLL_VERT, 12'd4095, 12'd4095);
        push_req(CMD_UPDATE, 2, 1'b0, 1, 255, MOTION_COMB_FWD, 0, 32767);
        push_req(CMD_UPDATE, 5, 1'b1, 1, 0, MOTION_CAMERA, 0, 32767);
        push_req(CMD_UPDATE, 2, 1'b0, 1, 200, MOTION_AUTO_FWD, 0, 0);

        set_config(SCROLL_STATIC, 12'd4095, 12'd4095);
        push_req(CMD_UPDATE, 3, 1'b0, 1, 0, MOTION_CAMERA, 1234, 4321);
        push_req(CMD_CLEAR, 3, 1'b0, 1, 0, MOTION_CAMERA, 0, 0);
        set_config(SCROLL_STATIC_ALT, 12'd640, 12'd256);
        push_req(CMD_UPDATE, 2, 1'b0, 1, 7, MOTION_AUTO_FWD, 0, 0);

        // zero wrap modulus, stale accumulators
        set_config(SCROLL_HORIZ, 12'd1, 12'd0);
        push_req(CMD_UPDATE, 2, 1'b0, 1, 200, MOTION_AUTO_FWD, 99, 0);
        push_req(CMD_UPDATE, 6, 1'b0, 9, 0, MOTION_CAMERA, 777, 0);
        set_config(SCROLL_VERT, 12'd0, 12'd0);
        push_req(CMD_UPDATE, 3, 1'b0, 4, 33, MOTION_COMB_BACK, 0, 12345);

        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    send_gap_pct   = 6;
                    recv_stall_pct = 79;
                end
                1:
                begin
                    send_gap_pct   = 79;
                    recv_stall_pct = 6;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int c = 0; c < CHUNKS; c++)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3:    sm = SCROLL_HORIZ;
                    4, 5, 6, 7:    sm = SCROLL_VERT;
                    8:             sm = SCROLL_STATIC;
                    default:       sm = SCROLL_STATIC_ALT;
                endcase
                set_config(sm, rand_plane(0), rand_plane(0));
                for (int i = 0; i < CHUNK; i++)
                    pending.push_back(rand_req());
            end
        end

        drain();
        repeat (100) @(negedge clk);
        if (fail_count == 0 && offset_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
